@@ rtl/core/lpht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear-probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W     = 32;
    localparam int HASH_W    = 32;
    localparam int VAL_W     = 64;
    localparam int LIMIT_W   = 9;
    localparam int USED_W    = 9;
    localparam int SLOT_W    = 2;
    localparam int ENTRY_W   = SLOT_W + KEY_W + VAL_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd192;

    typedef logic [1:0] t_op;
    localparam t_op OP_LOOKUP = 2'd0;
    localparam t_op OP_INSERT = 2'd1;
    localparam t_op OP_REMOVE = 2'd2;
    localparam t_op OP_CLEAR  = 2'd3;

    typedef logic [SLOT_W-1:0] t_slot;
    localparam t_slot SLOT_EMPTY = 2'd0;
    localparam t_slot SLOT_USED  = 2'd1;
    localparam t_slot SLOT_TOMB  = 2'd2;

    typedef logic [1:0] t_res;
    localparam t_res RES_OK      = 2'd0;
    localparam t_res RES_MISSING = 2'd1;
    localparam t_res RES_FULL    = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic capture;      // latch the accepted request
        logic sweep;        // write one empty slot of the clearing pass
        logic start_probe;  // read the home slot
        logic eval;         // examine the slot whose data arrives now
        logic set_missing;  // finish with key-not-found, no probe
        logic load_out;     // move the result into the output register
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hash_done;
        logic skip;
        logic is_clear;
        logic probe_end;
        logic sweep_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/lpht_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_req_if
// Request channel: valid/ready handshake with one table operation.
// ----------------------------------------------------------------------------
interface lpht_req_if import lpht_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [KEY_W-1:0]    key_id;
    logic [HASH_W-1:0]   key_hash;
    logic [VAL_W-1:0]    value_in;

    modport source (output valid, operation, key_id, key_hash, value_in, input ready);
    modport sink   (input valid, operation, key_id, key_hash, value_in, output ready);
endinterface

@@ rtl/core/lpht_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_rsp_if
// Response channel: valid/ready handshake with one operation result.
// ----------------------------------------------------------------------------
interface lpht_rsp_if import lpht_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [VAL_W-1:0]    value_out;
    logic                is_new;

    modport source (output valid, status, value_out, is_new, input ready);
    modport sink   (input valid, status, value_out, is_new, output ready);
endinterface

@@ rtl/core/lpht_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/lpht_ctl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ctl
// Sequencer of the hash table: clearing pass, hashing, probing, result.
// ----------------------------------------------------------------------------
module lpht_ctl import lpht_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.is_clear) begin
                    n_state = S_CLEAR;
                end else if (i_stat.skip) begin
                    o_cmd.set_missing = 1'b1;
                    n_state           = S_DONE;
                end else if (i_stat.hash_done) begin
                    o_cmd.start_probe = 1'b1;
                    n_state           = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd.eval = 1'b1;
                if (i_stat.probe_end) begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/lpht_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath of the hash table: slot memory, home-slot reduction, probe
// bookkeeping, use count, load limit register and output register.
// ----------------------------------------------------------------------------
module lpht_dp import lpht_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl_cmd           i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic [1:0]         i_operation,
    input  logic [KEY_W-1:0]   i_key_id,
    input  logic [HASH_W-1:0]  i_key_hash,
    input  logic [VAL_W-1:0]   i_value_in,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [VAL_W-1:0]   o_value_out,
    output logic               o_is_new
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] a);
        return (a == IW'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    // request
    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [IW-1:0]    home;
    logic             hash_done;

    // probe and sweep
    logic [IW-1:0]    r_eval_idx;
    logic [CW-1:0]    r_cnt;
    logic             r_tomb_seen;
    logic [IW-1:0]    r_tomb_slot;
    logic [IW-1:0]    r_sweep_idx;

    // counters and config
    logic [USED_W-1:0]  r_used;
    logic [LIMIT_W-1:0] r_limit;

    // result and output
    t_res             r_res_status;
    logic [VAL_W-1:0] r_res_value;
    logic             r_res_new;
    logic             r_out_valid;
    t_res             r_out_status;
    logic [VAL_W-1:0] r_out_value;
    logic             r_out_new;

    // memory
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    t_slot            rd_st;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic             hit;
    logic             is_tomb;
    logic             is_empty;
    logic             last;
    logic             probe_end;
    logic             tomb_any;
    logic [IW-1:0]    tomb_pos;
    logic             over_limit;
    logic             ins_ok;
    logic             used_inc;
    t_res             fin_status;
    logic [VAL_W-1:0] fin_value;
    logic             fin_new;

    // ------------------------------------------------------------------
    // Home slot: hash mod CAPACITY
    // ------------------------------------------------------------------
    generate
        if (POW2) begin : gen_pow2
            logic [IW-1:0] r_home;

            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_home <= i_key_hash[IW-1:0];
                end
            end

            assign home      = r_home;
            assign hash_done = 1'b1;
        end else begin : gen_recip
            // reciprocal multiply gives the quotient to within one; the
            // remainder then needs at most one subtract
            localparam int          SH         = 31 + IW;
            localparam logic [63:0] RECIP_FULL = (64'd1 << SH) / 64'(CAPACITY);
            localparam logic [31:0] RECIP      = RECIP_FULL[31:0];

            logic [1:0]        r_hstep;
            logic [HASH_W-1:0] r_hsh;
            logic [63:0]       r_prod;
            logic [IW:0]       r_rem;
            logic [IW-1:0]     r_home;
            logic [63:0]       quo;
            logic [IW:0]       quo_c;

            assign quo   = r_prod >> SH;
            assign quo_c = quo[IW:0] * (IW+1)'(CAPACITY);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_hstep <= 2'd3;
                end else if (i_cmd.capture) begin
                    r_hstep <= '0;
                end else if (r_hstep != 2'd3) begin
                    r_hstep <= r_hstep + 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_hsh <= i_key_hash;
                end
                r_prod <= 64'(r_hsh) * 64'(RECIP);
                r_rem  <= r_hsh[IW:0] - quo_c;
                r_home <= (r_rem >= (IW+1)'(CAPACITY))
                        ? IW'(r_rem - (IW+1)'(CAPACITY)) : r_rem[IW-1:0];
            end

            assign home      = r_home;
            assign hash_done = r_hstep == 2'd3;
        end
    endgenerate

    // ------------------------------------------------------------------
    // Slot memory: {status, key, value}
    // ------------------------------------------------------------------
    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // read the next slot ahead so its data is ready when the probe steps to it
    assign ram_raddr = i_cmd.start_probe ? home : f_inc(r_eval_idx);

    assign rd_st  = ram_rdata[ENTRY_W-1 -: SLOT_W];
    assign rd_key = ram_rdata[VAL_W +: KEY_W];
    assign rd_val = ram_rdata[VAL_W-1:0];

    assign hit        = (rd_st == SLOT_USED) && (rd_key == r_key);
    assign is_tomb    = rd_st == SLOT_TOMB;
    assign is_empty   = (rd_st != SLOT_USED) && (rd_st != SLOT_TOMB);
    assign last       = r_cnt == CW'(CAPACITY - 1);
    assign probe_end  = hit || is_empty || last;
    assign tomb_any   = r_tomb_seen || is_tomb;
    assign tomb_pos   = r_tomb_seen ? r_tomb_slot : r_eval_idx;
    assign over_limit = ({1'b0, r_used} + 1'b1) > {1'b0, r_limit};
    assign ins_ok     = (is_empty || tomb_any) && (tomb_any || !over_limit);

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_eval_idx;
        ram_wdata  = {SLOT_USED, r_key, r_val};
        fin_status = RES_MISSING;
        fin_value  = '0;
        fin_new    = 1'b0;
        used_inc   = 1'b0;
        if (i_cmd.sweep) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep_idx;
            ram_wdata = {SLOT_EMPTY, {(ENTRY_W-SLOT_W){1'b0}}};
        end else if (i_cmd.eval && probe_end) begin
            case (r_op)
                OP_LOOKUP: begin
                    if (hit) begin
                        fin_status = RES_OK;
                        fin_value  = rd_val;
                    end
                end
                OP_INSERT: begin
                    if (hit) begin
                        ram_we     = 1'b1;
                        fin_status = RES_OK;
                    end else if (ins_ok) begin
                        ram_we     = 1'b1;
                        ram_waddr  = tomb_pos;
                        fin_status = RES_OK;
                        fin_new    = 1'b1;
                        used_inc   = !tomb_any;
                    end else begin
                        fin_status = RES_FULL;
                    end
                end
                OP_REMOVE: begin
                    if (hit) begin
                        ram_we     = 1'b1;
                        ram_wdata  = {SLOT_TOMB, rd_key, rd_val};
                        fin_status = RES_OK;
                    end
                end
                default: begin
                    fin_status = RES_OK;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_idx <= '0;
            r_used      <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_tomb_seen <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.sweep) begin
                r_sweep_idx <= f_inc(r_sweep_idx);
                if (r_sweep_idx == IW'(CAPACITY - 1)) begin
                    r_used <= '0;
                end
            end else if (used_inc) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.start_probe) begin
                r_cnt       <= '0;
                r_tomb_seen <= 1'b0;
            end else if (i_cmd.eval && !probe_end) begin
                r_cnt <= r_cnt + 1'b1;
                if (is_tomb) begin
                    r_tomb_seen <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_key <= i_key_id;
            r_val <= i_value_in;
        end
        if (i_cmd.start_probe) begin
            r_eval_idx <= home;
        end else if (i_cmd.eval && !probe_end) begin
            r_eval_idx <= f_inc(r_eval_idx);
            if (is_tomb && !r_tomb_seen) begin
                r_tomb_slot <= r_eval_idx;
            end
        end
        if (i_cmd.set_missing) begin
            r_res_status <= RES_MISSING;
            r_res_value  <= '0;
            r_res_new    <= 1'b0;
        end else if (i_cmd.sweep && r_sweep_idx == IW'(CAPACITY - 1)) begin
            r_res_status <= RES_OK;
            r_res_value  <= '0;
            r_res_new    <= 1'b0;
        end else if (i_cmd.eval && probe_end) begin
            r_res_status <= fin_status;
            r_res_value  <= fin_value;
            r_res_new    <= fin_new;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_new    <= r_res_new;
        end
    end

    assign o_stat.hash_done  = hash_done;
    assign o_stat.skip       = ((r_op == OP_LOOKUP) || (r_op == OP_REMOVE)) && (r_used == '0);
    assign o_stat.is_clear   = r_op == OP_CLEAR;
    assign o_stat.probe_end  = probe_end;
    assign o_stat.sweep_last = r_sweep_idx == IW'(CAPACITY - 1);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value_out = r_out_value;
    assign o_is_new    = r_out_new;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> (r_cnt <= CW'(CAPACITY - 1)))
        else $error("probe ran past the table size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !i_cmd.load_out)
        else $error("pending result overwritten");

    a_used_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used_inc |=> (r_used <= USED_W'($past(r_limit))))
        else $error("use count passed the load limit");

    a_lookup_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_op == OP_LOOKUP) |-> !ram_we)
        else $error("lookup wrote the slot memory");

endmodule

@@ rtl/core/linear_probe_hash_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Fixed-size key/value table, open addressing with linear probing and
// tombstones.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one operation per transaction (lookup, insert/update,
//   remove, clear); o_rsp returns exactly one result per request, in order.
//   i_cfg_we/i_cfg_wdata write the load limit; write it only while idle.
//   Sequence: the request is latched, the home slot is read, then the probe
//   examines one slot per cycle over the single slot-memory read port (up
//   to CAPACITY probes), and the result is posted to the output register.
//   Lookup/remove on an empty table skips the probe. Clear sweeps all
//   slots. When CAPACITY is not a power of two the home slot comes from a
//   reciprocal multiply and one correcting subtract.
//   Reset: a clearing pass over all CAPACITY slots runs first; i_req.ready
//   stays low until it ends. Load limit resets to 192.
//   Stall: a finished result waits in the output register; the next request
//   is accepted and worked on, and its result holds until o_rsp frees up.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lpht_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    lpht_req_if.sink           i_req,
    lpht_rsp_if.source         o_rsp
);

    t_ctl_cmd cmd;
    t_dp_stat stat;
    logic     in_ready;

    lpht_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lpht_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_operation (i_req.operation),
        .i_key_id    (i_req.key_id),
        .i_key_hash  (i_req.key_hash),
        .i_value_in  (i_req.value_in),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_value_out (o_rsp.value_out),
        .o_is_new    (o_rsp.is_new)
    );

    assign i_req.ready = in_ready;

endmodule

@@ tb/lpht_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_table_checker
// Watches the request, response and load-limit ports of the hash table,
// keeps its own copy of the slot store, and checks every response in order.
// ----------------------------------------------------------------------------
module lpht_table_checker import lpht_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    lpht_req_if                i_req,
    lpht_rsp_if                i_rsp,
    output int                 o_fail_count,
    output int                 o_pending_count
);

    typedef struct {
        t_res             status;
        logic [VAL_W-1:0] value;
        logic             is_new;
    } t_outcome;

    t_slot              table_status [CAPACITY];
    logic [KEY_W-1:0]   table_key    [CAPACITY];
    logic [VAL_W-1:0]   table_value  [CAPACITY];
    logic [USED_W-1:0]  used_count;
    logic [LIMIT_W-1:0] load_limit;

    t_outcome           result_q [$];
    t_outcome           predicted;
    t_outcome           oldest;

    // Walk the chain from the home slot; report a key match, or the slot a
    // new key would take (first tombstone passed, else the ending empty slot).
    function automatic void walk_chain(
        input  logic [KEY_W-1:0]  key,
        input  logic [HASH_W-1:0] hash,
        output logic              hit,
        output logic              has_free,
        output logic              on_tomb,
        output int                slot
    );
        int   idx;
        logic tomb_seen;
        int   tomb_slot;
        idx       = int'(hash % 32'(CAPACITY));
        tomb_seen = 1'b0;
        tomb_slot = 0;
        hit       = 1'b0;
        has_free  = 1'b0;
        on_tomb   = 1'b0;
        slot      = 0;
        for (int n = 0; n < CAPACITY; n++) begin
            if (table_status[idx] == SLOT_USED) begin
                if (table_key[idx] == key) begin
                    hit  = 1'b1;
                    slot = idx;
                    return;
                end
            end else if (table_status[idx] == SLOT_TOMB) begin
                if (!tomb_seen) begin
                    tomb_seen = 1'b1;
                    tomb_slot = idx;
                end
            end else begin
                has_free = 1'b1;
                on_tomb  = tomb_seen;
                slot     = tomb_seen ? tomb_slot : idx;
                return;
            end
            idx = (idx + 1 == CAPACITY) ? 0 : idx + 1;
        end
        if (tomb_seen) begin
            has_free = 1'b1;
            on_tomb  = 1'b1;
            slot     = tomb_slot;
        end
    endfunction

    function automatic t_outcome apply_operation(
        input t_op               op,
        input logic [KEY_W-1:0]  key,
        input logic [HASH_W-1:0] hash,
        input logic [VAL_W-1:0]  val
    );
        t_outcome res;
        logic     hit;
        logic     has_free;
        logic     on_tomb;
        int       slot;
        res.status = RES_MISSING;
        res.value  = '0;
        res.is_new = 1'b0;
        case (op)
            OP_LOOKUP: begin
                if (used_count != 0) begin
                    walk_chain(key, hash, hit, has_free, on_tomb, slot);
                    if (hit) begin
                        res.status = RES_OK;
                        res.value  = table_value[slot];
                    end
                end
            end
            OP_INSERT: begin
                walk_chain(key, hash, hit, has_free, on_tomb, slot);
                if (hit) begin
                    table_value[slot] = val;
                    res.status        = RES_OK;
                end else if (!has_free) begin
                    res.status = RES_FULL;
                end else if (!on_tomb && int'(used_count) + 1 > int'(load_limit)) begin
                    res.status = RES_FULL;
                end else begin
                    if (!on_tomb) used_count = used_count + 1'b1;
                    table_status[slot] = SLOT_USED;
                    table_key[slot]    = key;
                    table_value[slot]  = val;
                    res.status         = RES_OK;
                    res.is_new         = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (used_count != 0) begin
                    walk_chain(key, hash, hit, has_free, on_tomb, slot);
                    if (hit) begin
                        table_status[slot] = SLOT_TOMB;
                        res.status         = RES_OK;
                    end
                end
            end
            default: begin
                foreach (table_status[i]) table_status[i] = SLOT_EMPTY;
                used_count = '0;
                res.status = RES_OK;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (table_status[i]) table_status[i] = SLOT_EMPTY;
            used_count   = '0;
            load_limit   = LIMIT_RESET;
            o_fail_count = 0;
            result_q.delete();
        end else begin
            if (i_cfg_we) load_limit = i_cfg_wdata;
            // Check before predicting: a request never answers in its own cycle
            if (i_rsp.valid && i_rsp.ready) begin
                if (result_q.size() == 0) begin
                    $error("response with no request outstanding: status %0d", i_rsp.status);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    oldest = result_q.pop_front();
                    if (i_rsp.status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, i_rsp.status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.value_out !== oldest.value) begin
                        $error("value_out: expected %h, actual %h",
                               oldest.value, i_rsp.value_out);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.is_new !== oldest.is_new) begin
                        $error("is_new: expected %0d, actual %0d", oldest.is_new, i_rsp.is_new);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                predicted = apply_operation(t_op'(i_req.operation), i_req.key_id,
                                            i_req.key_hash, i_req.value_in);
                result_q.push_back(predicted);
            end
        end
        o_pending_count = result_q.size();
    end

endmodule

@@ tb/linear_probe_hash_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Drives table operations over a clustered key pool and a fill to capacity,
// under several load limits, with random gaps on both channels; the checker
// beside the table predicts and compares every response.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_test;
    import lpht_pkg::*;

    localparam int CAPACITY       = 256;
    localparam int POOL_N         = 48;
    localparam int WATCHDOG_LIMIT = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;

    int                 fail_count;
    int                 pending_count;
    int                 stall_cycles;
    int                 requests_sent;
    int                 limit_writes;
    bit                 gaps_on;

    logic [KEY_W-1:0]   pool_key  [POOL_N];
    logic [HASH_W-1:0]  pool_hash [POOL_N];

    lpht_req_if req_if ();
    lpht_rsp_if rsp_if ();

    linear_probe_hash_table #(.CAPACITY(CAPACITY)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    lpht_table_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req           (req_if),
        .i_rsp           (rsp_if),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_if.ready <= gaps_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
    end

    // Restart the count on every transaction on either channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("linear_probe_hash_table_test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Hold valid until the transaction completes; return right after that edge
    task automatic send_op(
        input t_op               op,
        input logic [KEY_W-1:0]  key,
        input logic [HASH_W-1:0] hash,
        input logic [VAL_W-1:0]  val
    );
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < 25) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.key_id    <= key;
        req_if.key_hash  <= hash;
        req_if.value_in  <= val;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] limit);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_writes++;
    endtask

    // Mostly keys from the clustered pool with their own hash; some noise
    task automatic pool_op(input int clear_pct);
        int  r;
        int  idx;
        t_op op;
        r   = $urandom_range(0, 99);
        idx = $urandom_range(0, POOL_N - 1);
        if (r < clear_pct)  op = OP_CLEAR;
        else if (r < 45)    op = OP_INSERT;
        else if (r < 75)    op = OP_LOOKUP;
        else                op = OP_REMOVE;
        if ($urandom_range(0, 99) < 6)
            send_op(op, $urandom, $urandom, {$urandom, $urandom});
        else
            send_op(op, pool_key[idx], pool_hash[idx], {$urandom, $urandom});
    endtask

    task automatic pool_phase(input int n_items, input int clear_pct);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) drain_results();
            pool_op(clear_pct);
        end
    endtask

    initial begin
        logic [7:0] home;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_LOOKUP;
        req_if.key_id    = '0;
        req_if.key_hash  = '0;
        req_if.value_in  = '0;
        rsp_if.ready     = 1'b0;
        stall_cycles     = 0;
        requests_sent    = 0;
        limit_writes     = 0;
        gaps_on          = 1'b1;

        // Cluster home slots around the wrap point and two other spots
        for (int i = 0; i < POOL_N; i++) begin
            case (i % 4)
                0:       home = 8'd252;
                1:       home = 8'd0;
                2:       home = 8'd120;
                default: home = 8'd60;
            endcase
            home         = home + 8'($urandom_range(0, 5));
            pool_key[i]  = $urandom;
            pool_hash[i] = {24'($urandom), home};
        end

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Wait out the clearing pass after reset
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);

        // Empty table: lookup and remove miss without probing
        send_op(OP_LOOKUP, '0, '0, '0);
        send_op(OP_REMOVE, '1, '1, '1);
        send_op(OP_INSERT, '0, '0, '0);
        send_op(OP_INSERT, '1, '1, '1);
        // Home slot 255 taken, slot 0 taken: wrap to slot 1
        send_op(OP_INSERT, 32'd1, '1, 64'hDEAD_BEEF_0123_4567);
        send_op(OP_LOOKUP, 32'd1, '1, '0);
        send_op(OP_INSERT, '0, '0, '1);
        send_op(OP_LOOKUP, '0, '0, '0);
        send_op(OP_REMOVE, '1, '1, '0);
        send_op(OP_LOOKUP, '1, '1, '0);
        // New key lands on the tombstone it passed
        send_op(OP_INSERT, 32'd2, '1, 64'h5555_AAAA_5555_AAAA);
        send_op(OP_LOOKUP, 32'd2, '1, '0);
        send_op(OP_REMOVE, 32'd7, '0, '0);
        send_op(OP_CLEAR, '0, '0, '0);
        send_op(OP_LOOKUP, '0, '0, '0);

        write_limit(9'd1);
        send_op(OP_INSERT, 32'h10, 32'h40, 64'h1);
        send_op(OP_INSERT, 32'h11, 32'h40, 64'h2);
        // Update at the limit is never refused
        send_op(OP_INSERT, 32'h10, 32'h40, 64'h3);
        send_op(OP_REMOVE, 32'h10, 32'h40, '0);
        send_op(OP_INSERT, 32'h11, 32'h40, 64'h4);

        write_limit(9'd0);
        send_op(OP_INSERT, 32'h12, 32'h80, 64'h5);
        send_op(OP_REMOVE, 32'h11, 32'h40, '0);
        send_op(OP_INSERT, 32'h12, 32'h40, 64'h6);
        send_op(OP_CLEAR, '0, '0, '0);

        write_limit(9'd255);
        pool_phase(250, 1);

        write_limit(9'd8);
        pool_phase(100, 2);

        // Fill to capacity with mostly fresh keys, no gaps on either side for the first 150 requests
        write_limit(9'd256);
        gaps_on = 1'b0;
        for (int i = 0; i < 300; i++) begin
            if (i == 150) gaps_on = 1'b1;
            if ($urandom_range(0, 99) < 85)
                send_op(OP_INSERT, $urandom, $urandom, {$urandom, $urandom});
            else
                pool_op(0);
        end

        // Table stays full: only tombstones take new keys
        write_limit(9'd511);
        pool_phase(100, 0);

        write_limit(9'd64);
        send_op(OP_CLEAR, '0, '0, '0);
        pool_phase(150, 3);

        drain_results();
        repeat (20) @(negedge i_clk);
        $display("%0d requests sent under %0d load-limit writes, from empty-table misses",
                 requests_sent, limit_writes);
        $display("to a table filled to capacity with tombstone reuse and refused inserts");
        if (fail_count == 0) begin
            $display("linear_probe_hash_table_test passed");
        end else begin
            $display("linear_probe_hash_table_test failed");
        end
        $finish;
    end

endmodule

@@ linear_probe_hash_table.f @@
rtl/core/lpht_pkg.sv
rtl/core/lpht_req_if.sv
rtl/core/lpht_rsp_if.sv
rtl/core/lpht_ram.sv
rtl/core/lpht_ctl.sv
rtl/core/lpht_dp.sv
rtl/core/linear_probe_hash_table.sv
tb/lpht_table_checker.sv
tb/linear_probe_hash_table_test.sv
